### design/poi_pkg.sv
// poi_pkg: constants, types and the cordic angle table of the planar odometry integrator
// no dependencies; imported by the interfaces and every module of the block
`default_nettype none

package poi_pkg;

	localparam int ROTATE_STEPS  = 16;
	localparam int POSITION_BITS = 56;

	localparam int ATAN_ENTRIES = 24;
	localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);
	localparam int STEP_W       = $clog2(ROTATE_STEPS);
	localparam int GAIN_Q16     = 39797;

	localparam int CORDIC_W = 42;
	localparam int ANG_W    = 34;
	localparam int RES_W    = CORDIC_W - 16;

	localparam int MUL_A_W = RES_W;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int PROD_W   = 60;
	localparam int SUM_W    = ((POSITION_BITS > PROD_W) ? POSITION_BITS : PROD_W) + 1;
	localparam int HEAD_W   = 36;
	localparam int POS_SH_W = ((POSITION_BITS - 20) > 32) ? (POSITION_BITS - 20) : 33;

	// item kinds
	localparam logic CMD_VELOCITY = 1'b0;
	localparam logic CMD_TICK     = 1'b1;

	localparam logic signed [CORDIC_W-1:0] UNIT_GAINED = CORDIC_W'(longint'(GAIN_Q16) <<< 16);
	localparam logic signed [RES_W-1:0]    QUAT_MAX    = RES_W'(65536);
	localparam logic signed [RES_W-1:0]    QUAT_MIN    = RES_W'(-65536);

	typedef logic [31:0]        ts_t;
	typedef logic [23:0]        limit_t;
	typedef logic signed [23:0] vel_t;
	typedef logic signed [31:0] pos_t;
	typedef logic [15:0]        bangle_t;
	typedef logic signed [17:0] quat_t;

	typedef struct packed {
		logic                       start;
		logic [31:0]                angle;
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
	} cordic_req_t;

	// atan(2^-i) in 2^-32 turn
	function automatic logic [29:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
		logic [29:0] v;
		unique case (idx)
			5'd0:    v = 30'd536870912;
			5'd1:    v = 30'd316933406;
			5'd2:    v = 30'd167458907;
			5'd3:    v = 30'd85004756;
			5'd4:    v = 30'd42667331;
			5'd5:    v = 30'd21354465;
			5'd6:    v = 30'd10679838;
			5'd7:    v = 30'd5340245;
			5'd8:    v = 30'd2670163;
			5'd9:    v = 30'd1335087;
			5'd10:   v = 30'd667544;
			5'd11:   v = 30'd333772;
			5'd12:   v = 30'd166886;
			5'd13:   v = 30'd83443;
			5'd14:   v = 30'd41722;
			5'd15:   v = 30'd20861;
			5'd16:   v = 30'd10430;
			5'd17:   v = 30'd5215;
			5'd18:   v = 30'd2608;
			5'd19:   v = 30'd1304;
			5'd20:   v = 30'd652;
			5'd21:   v = 30'd326;
			5'd22:   v = 30'd163;
			5'd23:   v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

### design/poi_intf.sv
// poi_intf: valid/ready channel interfaces for items, results and the timeout register
// depends on poi_pkg for the payload types
`default_nettype none

interface poi_in_if import poi_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       cmd;
	ts_t        timestamp;
	vel_t       cmd_vel_x;
	vel_t       cmd_vel_y;
	vel_t       cmd_vel_turn;

	modport source (output valid, cmd, timestamp, cmd_vel_x, cmd_vel_y, cmd_vel_turn,
		input ready);
	modport sink (input valid, cmd, timestamp, cmd_vel_x, cmd_vel_y, cmd_vel_turn,
		output ready);
endinterface

interface poi_out_if import poi_pkg::*; ();
	logic    valid;
	logic    ready;
	pos_t    pos_x;
	pos_t    pos_y;
	bangle_t heading_angle;
	quat_t   quat_z;
	quat_t   quat_w;
	vel_t    out_vel_x;
	vel_t    out_vel_y;
	vel_t    out_vel_turn;
	logic    timed_out;

	modport source (output valid, pos_x, pos_y, heading_angle, quat_z, quat_w, out_vel_x,
		out_vel_y, out_vel_turn, timed_out, input ready);
	modport sink (input valid, pos_x, pos_y, heading_angle, quat_z, quat_w, out_vel_x,
		out_vel_y, out_vel_turn, timed_out, output ready);
endinterface

interface poi_cfg_if import poi_pkg::*; ();
	logic   valid;
	logic   ready;
	limit_t data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

### design/poi_mul.sv
// poi_mul: shared signed multiplier with registered product
// depends on poi_pkg for operand widths
`default_nettype none

module poi_mul import poi_pkg::*; (
	input  logic                      clk,
	input  logic signed [MUL_A_W-1:0] a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [MUL_P_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

`default_nettype wire

### design/poi_cordic.sv
// poi_cordic: iterative cordic rotator, one micro-rotation per cycle, quarter-turn pre-rotation
// depends on poi_pkg for widths, the request struct and the angle table
`default_nettype none

module poi_cordic import poi_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cordic_req_t             req,
	output logic                    done,
	output logic signed [RES_W-1:0] res_x,
	output logic signed [RES_W-1:0] res_y
);

	logic [31:0]                ang_ofs;
	logic [1:0]                 quad;
	logic [31:0]                resid;
	logic signed [CORDIC_W-1:0] x_pre, y_pre;
	logic signed [CORDIC_W-1:0] dx, dy, rnd_x, rnd_y;
	logic signed [ANG_W-1:0]    at_s;
	logic                       last_step;

	logic                       run_q, done_q;
	logic [STEP_W-1:0]          step_q;
	logic signed [CORDIC_W-1:0] x_q, y_q;
	logic signed [ANG_W-1:0]    r_q;

	always_comb begin
		ang_ofs = req.angle + 32'h2000_0000;
		quad    = ang_ofs[31:30];
		resid   = req.angle - {quad, 30'b0};
		unique case (quad)
			2'd0: begin
				x_pre = req.x;
				y_pre = req.y;
			end
			2'd1: begin
				x_pre = -req.y;
				y_pre = req.x;
			end
			2'd2: begin
				x_pre = -req.x;
				y_pre = -req.y;
			end
			default: begin
				x_pre = req.y;
				y_pre = -req.x;
			end
		endcase
	end

	assign dx        = y_q >>> step_q;
	assign dy        = x_q >>> step_q;
	assign at_s      = signed'(ANG_W'(atan_lut(ATAN_IDX_W'(step_q))));
	assign last_step = (step_q == STEP_W'(ROTATE_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= run_q && last_step;
			if (req.start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				if (last_step) begin
					run_q <= 1'b0;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= x_pre;
			y_q <= y_pre;
			r_q <= ANG_W'(signed'(resid));
		end else if (run_q) begin
			if (!r_q[ANG_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				r_q <= r_q - at_s;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				r_q <= r_q + at_s;
			end
		end
	end

	// round half up to the input scale
	assign rnd_x = (x_q + CORDIC_W'(32768)) >>> 16;
	assign rnd_y = (y_q + CORDIC_W'(32768)) >>> 16;
	assign res_x = rnd_x[RES_W-1:0];
	assign res_y = rnd_y[RES_W-1:0];
	assign done  = done_q;

endmodule

`default_nettype wire

### design/planar_odometry_integrator.sv
// planar_odometry_integrator: dead-reckoning pose integrator, top level and sequencer
// depends on poi_pkg, poi_intf, poi_mul and poi_cordic
//
//   port   dir   contents
//   item   sink  cmd, timestamp, cmd_vel_x/y/turn
//   pose   src   pos_x/y, heading_angle, quat_z/w, out_vel_x/y/turn, timed_out
//   cfg    sink  timeout_limit write data, always ready
//
// a velocity command is taken in the idle step and gives no result
// a tick makes two passes of the cordic and eight passes of the
// shared multiplier, all in series
// the result sits in an output register, so the next item is taken while it waits
// a tick finishing while the previous result is still stalled waits in its last step
// arst_n clears pose, heading, held velocities, times and timeout_limit to 524288
`default_nettype none

module planar_odometry_integrator import poi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	poi_cfg_if.sink    cfg,
	poi_in_if.sink     item,
	poi_out_if.source  pose
);

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_GX    = 16'h0002,
		S_GY    = 16'h0004,
		S_ROT1  = 16'h0008,
		S_WAIT1 = 16'h0010,
		S_MXL   = 16'h0020,
		S_MXH   = 16'h0040,
		S_MXA   = 16'h0080,
		S_AX    = 16'h0100,
		S_MYA   = 16'h0200,
		S_AY    = 16'h0400,
		S_MTA   = 16'h0800,
		S_AH    = 16'h1000,
		S_ROT2  = 16'h2000,
		S_WAIT2 = 16'h4000,
		S_OUT   = 16'h8000
	} state_t;

	function automatic logic signed [POSITION_BITS-1:0] acc_sat(
		input logic signed [SUM_W-1:0] s);
		if (&s[SUM_W-1:POSITION_BITS-1] || ~|s[SUM_W-1:POSITION_BITS-1]) begin
			return s[POSITION_BITS-1:0];
		end else if (s[SUM_W-1]) begin
			return {1'b1, {(POSITION_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(POSITION_BITS-1){1'b1}}};
		end
	endfunction

	function automatic pos_t pos_sat(input logic signed [POSITION_BITS-1:0] acc);
		logic signed [POSITION_BITS-1:0] sh;
		logic signed [POS_SH_W-1:0]      ext;
		sh  = acc >>> 20;
		ext = POS_SH_W'(sh);
		if (&ext[POS_SH_W-1:31] || ~|ext[POS_SH_W-1:31]) begin
			return ext[31:0];
		end else if (ext[POS_SH_W-1]) begin
			return 32'sh8000_0000;
		end else begin
			return 32'sh7fff_ffff;
		end
	endfunction

	function automatic quat_t quat_clamp(input logic signed [RES_W-1:0] v);
		if (v > QUAT_MAX) begin
			return quat_t'(QUAT_MAX);
		end else if (v < QUAT_MIN) begin
			return quat_t'(QUAT_MIN);
		end else begin
			return v[17:0];
		end
	endfunction

	state_t                          state_q;
	limit_t                          limit_q;
	logic signed [POSITION_BITS-1:0] acc_x_q, acc_y_q;
	logic [HEAD_W-1:0]               acc_head_q;
	vel_t                            vel_x_q, vel_y_q, vel_turn_q;
	ts_t                             last_tick_q, last_cmd_q, dt_q;
	logic                            timed_out_q;
	logic signed [CORDIC_W-1:0]      gx_q;
	logic signed [RES_W-1:0]         wx_q, wy_q;
	logic signed [PROD_W-1:0]        prod_q;
	quat_t                           qz_q, qw_q;

	logic                            out_valid_q;
	pos_t                            out_pos_x_q, out_pos_y_q;
	bangle_t                         out_head_q;
	quat_t                           out_qz_q, out_qw_q;
	vel_t                            out_vx_q, out_vy_q, out_vt_q;
	logic                            out_to_q;

	logic signed [MUL_A_W-1:0]       mul_a;
	logic signed [MUL_B_W-1:0]       mul_b;
	logic signed [MUL_P_W-1:0]       mul_p;
	logic signed [MUL_B_W-1:0]       dt_lo, dt_hi;
	cordic_req_t                     cor_req;
	logic                            cor_done;
	logic signed [RES_W-1:0]         cor_x, cor_y;

	logic                            item_take, tick_take, cmd_take, stale;
	logic                            out_free;
	ts_t                             age;
	logic signed [PROD_W-1:0]        p_ext;
	logic signed [SUM_W-1:0]         sum;

	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign item_take  = item.valid && item.ready;
	assign tick_take  = item_take && (item.cmd == CMD_TICK);
	assign cmd_take   = item_take && (item.cmd == CMD_VELOCITY);
	assign age        = item.timestamp - last_cmd_q;
	assign stale      = age > {8'b0, limit_q};
	assign out_free   = !out_valid_q || pose.ready;

	assign dt_lo = signed'({1'b0, dt_q[15:0]});
	assign dt_hi = signed'({1'b0, dt_q[31:16]});
	assign p_ext = PROD_W'(mul_p);
	assign sum   = SUM_W'(state_q == S_AX ? acc_x_q : acc_y_q) + SUM_W'(prod_q);

	// operand selection for the shared multiplier
	always_comb begin
		unique case (state_q)
			S_GX: begin
				mul_a = MUL_A_W'(vel_x_q);
				mul_b = MUL_B_W'(GAIN_Q16);
			end
			S_GY: begin
				mul_a = MUL_A_W'(vel_y_q);
				mul_b = MUL_B_W'(GAIN_Q16);
			end
			S_MXL: begin
				mul_a = wx_q;
				mul_b = dt_lo;
			end
			S_MXH: begin
				mul_a = wx_q;
				mul_b = dt_hi;
			end
			S_MXA: begin
				mul_a = wy_q;
				mul_b = dt_lo;
			end
			S_AX: begin
				mul_a = wy_q;
				mul_b = dt_hi;
			end
			S_MYA: begin
				mul_a = MUL_A_W'(vel_turn_q);
				mul_b = dt_lo;
			end
			S_AY: begin
				mul_a = MUL_A_W'(vel_turn_q);
				mul_b = dt_hi;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		cor_req.start = (state_q == S_ROT1) || (state_q == S_ROT2);
		if (state_q == S_ROT1) begin
			cor_req.angle = acc_head_q[HEAD_W-1:HEAD_W-32];
			cor_req.x     = gx_q;
			cor_req.y     = mul_p[CORDIC_W-1:0];
		end else begin
			cor_req.angle = {1'b0, acc_head_q[HEAD_W-1:HEAD_W-31]};
			cor_req.x     = UNIT_GAINED;
			cor_req.y     = '0;
		end
	end

	poi_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	poi_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cor_req),
		.done   (cor_done),
		.res_x  (cor_x),
		.res_y  (cor_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			limit_q     <= limit_t'(524288);
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			acc_head_q  <= '0;
			vel_x_q     <= '0;
			vel_y_q     <= '0;
			vel_turn_q  <= '0;
			last_tick_q <= '0;
			last_cmd_q  <= '0;
			timed_out_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				limit_q <= cfg.data;
			end
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pose.valid && pose.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						vel_x_q    <= item.cmd_vel_x;
						vel_y_q    <= item.cmd_vel_y;
						vel_turn_q <= item.cmd_vel_turn;
						last_cmd_q <= item.timestamp;
					end else if (tick_take) begin
						if (stale) begin
							vel_x_q    <= '0;
							vel_y_q    <= '0;
							vel_turn_q <= '0;
						end
						timed_out_q <= stale;
						last_tick_q <= item.timestamp;
						state_q     <= S_GX;
					end
				end
				S_GX:    state_q <= S_GY;
				S_GY:    state_q <= S_ROT1;
				S_ROT1:  state_q <= S_WAIT1;
				S_WAIT1: begin
					if (cor_done) begin
						state_q <= S_MXL;
					end
				end
				S_MXL:   state_q <= S_MXH;
				S_MXH:   state_q <= S_MXA;
				S_MXA:   state_q <= S_AX;
				S_AX: begin
					acc_x_q <= acc_sat(sum);
					state_q <= S_MYA;
				end
				S_MYA:   state_q <= S_AY;
				S_AY: begin
					acc_y_q <= acc_sat(sum);
					state_q <= S_MTA;
				end
				S_MTA:   state_q <= S_AH;
				S_AH: begin
					acc_head_q <= acc_head_q + prod_q[HEAD_W-1:0];
					state_q    <= S_ROT2;
				end
				S_ROT2:  state_q <= S_WAIT2;
				S_WAIT2: begin
					if (cor_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (tick_take) begin
			dt_q <= item.timestamp - last_tick_q;
		end
		if (state_q == S_GY) begin
			gx_q <= mul_p[CORDIC_W-1:0];
		end
		if (state_q == S_WAIT1 && cor_done) begin
			wx_q <= cor_x;
			wy_q <= cor_y;
		end
		if (state_q == S_WAIT2 && cor_done) begin
			qw_q <= quat_clamp(cor_x);
			qz_q <= quat_clamp(cor_y);
		end
		if (state_q == S_MXH || state_q == S_AX || state_q == S_AY) begin
			prod_q <= p_ext;
		end else if (state_q == S_MXA || state_q == S_MYA || state_q == S_MTA) begin
			prod_q <= prod_q + (p_ext <<< 16);
		end
		if (state_q == S_OUT && out_free) begin
			out_pos_x_q <= pos_sat(acc_x_q);
			out_pos_y_q <= pos_sat(acc_y_q);
			out_head_q  <= acc_head_q[HEAD_W-1:HEAD_W-16];
			out_qz_q    <= qz_q;
			out_qw_q    <= qw_q;
			out_vx_q    <= vel_x_q;
			out_vy_q    <= vel_y_q;
			out_vt_q    <= vel_turn_q;
			out_to_q    <= timed_out_q;
		end
	end

	assign pose.valid         = out_valid_q;
	assign pose.pos_x         = out_pos_x_q;
	assign pose.pos_y         = out_pos_y_q;
	assign pose.heading_angle = out_head_q;
	assign pose.quat_z        = out_qz_q;
	assign pose.quat_w        = out_qw_q;
	assign pose.out_vel_x     = out_vx_q;
	assign pose.out_vel_y     = out_vy_q;
	assign pose.out_vel_turn  = out_vt_q;
	assign pose.timed_out     = out_to_q;

	a_cordic_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == S_WAIT1 || state_q == S_WAIT2))
		else $error("cordic finished outside a wait step");

	a_stale_zero_vel: assert property (@(posedge clk) disable iff (!arst_n)
		(pose.valid && pose.timed_out) |->
		(pose.out_vel_x == '0 && pose.out_vel_y == '0 && pose.out_vel_turn == '0))
		else $error("timed-out result carries nonzero velocity");

	a_result_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised without finishing a tick");

	a_quat_range: assert property (@(posedge clk) disable iff (!arst_n)
		pose.valid |-> (pose.quat_w <= 18'sd65536 && pose.quat_w >= -18'sd65536 &&
		pose.quat_z <= 18'sd65536 && pose.quat_z >= -18'sd65536))
		else $error("quaternion component beyond unit range");

endmodule

`default_nettype wire
